// ===== design/mae_pkg.sv =====
// Shared types, codes and the microcode ROM of the matrix arithmetic engine.
// Used by the sequencer, the datapath, the top level and the port checker.
package mae_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 4;
  localparam int DIM_W  = 5;

  typedef enum logic [1:0] {
    OP_TRANSPOSE = 2'd0,
    OP_ADD       = 2'd1,
    OP_SUB       = 2'd2,
    OP_MUL       = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_LOAD_A = 2'd0,
    KIND_LOAD_B = 2'd1,
    KIND_READ   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CFG_OPERATION = 2'd0,
    CFG_ROWS_A    = 2'd1,
    CFG_COLS_A    = 2'd2,
    CFG_COLS_B    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]              kind;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     out_of_shape;
  } out_item_t;

  typedef enum logic [3:0] {
    U_IDLE, U_LDA, U_LDB, U_TR_RD, U_TR_RES, U_ADD_RD, U_ADD_RES, U_SUB_RD, U_SUB_RES,
    U_MUL_LOOP, U_MUL_D1, U_MUL_D2, U_MUL_RND, U_OOS, U_EMIT
  } upc_e;

  typedef enum logic [1:0] {RD_NONE, RD_TRANS, RD_ELEM, RD_MAC} rd_sel_e;

  typedef enum logic [2:0] {
    RES_HOLD, RES_ELEM_A, RES_ADD, RES_SUB, RES_ROUND, RES_OOS
  } res_sel_e;

  typedef enum logic [1:0] {J_GOTO, J_LOOP, J_DISPATCH, J_EMIT} jump_e;

  typedef struct packed {
    rd_sel_e  rd_sel;
    res_sel_e res_sel;
    jump_e    jump;
    upc_e     target;
    logic     wr_a;
    logic     wr_b;
    logic     clr;
    logic     emit;
  } ctl_t;

  typedef struct packed {
    ctl_t             ctl;
    logic             take;
    logic [DIM_W-1:0] k;
  } seq_out_t;

  function automatic ctl_t rom(upc_e addr);
    ctl_t w;
    w = '{rd_sel: RD_NONE, res_sel: RES_HOLD, jump: J_GOTO, target: U_IDLE,
          wr_a: 1'b0, wr_b: 1'b0, clr: 1'b0, emit: 1'b0};
    case (addr)
      U_IDLE: begin
        w.jump = J_DISPATCH;
        w.clr  = 1'b1;
      end
      U_LDA:     w.wr_a = 1'b1;
      U_LDB:     w.wr_b = 1'b1;
      U_TR_RD: begin
        w.rd_sel = RD_TRANS;
        w.target = U_TR_RES;
      end
      U_TR_RES: begin
        w.res_sel = RES_ELEM_A;
        w.target  = U_EMIT;
      end
      U_ADD_RD: begin
        w.rd_sel = RD_ELEM;
        w.target = U_ADD_RES;
      end
      U_ADD_RES: begin
        w.res_sel = RES_ADD;
        w.target  = U_EMIT;
      end
      U_SUB_RD: begin
        w.rd_sel = RD_ELEM;
        w.target = U_SUB_RES;
      end
      U_SUB_RES: begin
        w.res_sel = RES_SUB;
        w.target  = U_EMIT;
      end
      U_MUL_LOOP: begin
        w.rd_sel = RD_MAC;
        w.jump   = J_LOOP;
        w.target = U_MUL_D1;
      end
      U_MUL_D1:  w.target = U_MUL_D2;
      U_MUL_D2:  w.target = U_MUL_RND;
      U_MUL_RND: begin
        w.res_sel = RES_ROUND;
        w.target  = U_EMIT;
      end
      U_OOS: begin
        w.res_sel = RES_OOS;
        w.target  = U_EMIT;
      end
      U_EMIT: begin
        w.jump = J_EMIT;
        w.emit = 1'b1;
      end
      default: w.target = U_IDLE;
    endcase
    return w;
  endfunction

endpackage

// ===== design/matrix_arith_engine.sv =====
// Matrix engine top level: configuration registers, output register, sequencer and datapath.
// Loads are written in U_LDA or U_LDB; transpose, add and subtract reads pass a store read step,
// a result step and U_EMIT; a multiply reads once per cols_a term, then U_MUL_D1/D2/RND, U_EMIT.
// One item is worked at a time; the next is accepted once the result sits in the output register.
// Reset clears the configuration to transpose with 1x1 shapes; stores are undefined until written.
module matrix_arith_engine #(
  parameter int MAX_DIM = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  mae_pkg::in_item_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output mae_pkg::out_item_t        out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [1:0]                cfg_index_i,
  input  logic [mae_pkg::DIM_W-1:0] cfg_data_i
);

  mae_pkg::op_e op_q;
  logic [mae_pkg::DIM_W-1:0] rows_a_q, cols_a_q, cols_b_q;
  mae_pkg::seq_out_t seq;
  mae_pkg::out_item_t res, out_q;
  logic out_vld_q, out_vld_d, out_free, out_load;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q     <= mae_pkg::OP_TRANSPOSE;
      rows_a_q <= mae_pkg::DIM_W'(1);
      cols_a_q <= mae_pkg::DIM_W'(1);
      cols_b_q <= mae_pkg::DIM_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mae_pkg::CFG_OPERATION: op_q     <= mae_pkg::op_e'(cfg_data_i[1:0]);
        mae_pkg::CFG_ROWS_A:    rows_a_q <= cfg_data_i;
        mae_pkg::CFG_COLS_A:    cols_a_q <= cfg_data_i;
        mae_pkg::CFG_COLS_B:    cols_b_q <= cfg_data_i;
        default:                op_q     <= op_q;
      endcase
    end
  end

  mae_seq #(.MAX_DIM(MAX_DIM)) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_data_i),
    .op_i       (op_q),
    .rows_a_i   (rows_a_q),
    .cols_a_i   (cols_a_q),
    .cols_b_i   (cols_b_q),
    .out_free_i (out_free),
    .in_stall_o (in_stall_o),
    .seq_o      (seq)
  );

  mae_dp #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .seq_i     (seq),
    .in_item_i (in_data_i),
    .res_o     (res)
  );

  always_comb begin
    out_free  = !out_vld_q || !out_stall_i;
    out_load  = seq.ctl.emit && out_free;
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= res;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/mae_seq.sv =====
// Microcode sequencer: step counter, dispatch on accepted items and loop counter.
// Reads its control words from the ROM in mae_pkg.
module mae_seq #(
  parameter int MAX_DIM = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  mae_pkg::in_item_t           in_item_i,
  input  mae_pkg::op_e                op_i,
  input  logic [mae_pkg::DIM_W-1:0]   rows_a_i,
  input  logic [mae_pkg::DIM_W-1:0]   cols_a_i,
  input  logic [mae_pkg::DIM_W-1:0]   cols_b_i,
  input  logic                        out_free_i,
  output logic                        in_stall_o,
  output mae_pkg::seq_out_t           seq_o
);

  mae_pkg::upc_e upc_q, upc_d, disp;
  mae_pkg::ctl_t ctl;
  logic [mae_pkg::DIM_W-1:0] k_q, k_d;
  logic [mae_pkg::DIM_W-1:0] ra, ca, cb, r, c, br, bc;
  logic take, k_last;

  always_comb begin
    ra = (int'(rows_a_i) > MAX_DIM) ? mae_pkg::DIM_W'(MAX_DIM) : rows_a_i;
    ca = (int'(cols_a_i) > MAX_DIM) ? mae_pkg::DIM_W'(MAX_DIM) : cols_a_i;
    cb = (int'(cols_b_i) > MAX_DIM) ? mae_pkg::DIM_W'(MAX_DIM) : cols_b_i;
    r  = {1'b0, in_item_i.row};
    c  = {1'b0, in_item_i.col};
    br = (op_i == mae_pkg::OP_MUL) ? ca : ra;
    bc = (op_i == mae_pkg::OP_MUL) ? cb : ca;
  end

  always_comb begin
    ctl        = mae_pkg::rom(upc_q);
    in_stall_o = (upc_q != mae_pkg::U_IDLE);
    take       = in_valid_i && (upc_q == mae_pkg::U_IDLE);
    seq_o.ctl  = ctl;
    seq_o.take = take;
    seq_o.k    = k_q;
  end

  always_comb begin
    disp = mae_pkg::U_IDLE;
    case (in_item_i.kind)
      mae_pkg::KIND_LOAD_A: begin
        if (r < ra && c < ca) disp = mae_pkg::U_LDA;
      end
      mae_pkg::KIND_LOAD_B: begin
        if (r < br && c < bc) disp = mae_pkg::U_LDB;
      end
      mae_pkg::KIND_READ: begin
        disp = mae_pkg::U_OOS;
        case (op_i)
          mae_pkg::OP_TRANSPOSE: begin
            if (r < ca && c < ra) disp = mae_pkg::U_TR_RD;
          end
          mae_pkg::OP_ADD: begin
            if (r < ra && c < ca) disp = mae_pkg::U_ADD_RD;
          end
          mae_pkg::OP_SUB: begin
            if (r < ra && c < ca) disp = mae_pkg::U_SUB_RD;
          end
          mae_pkg::OP_MUL: begin
            if (r < ra && c < cb) begin
              disp = (ca == '0) ? mae_pkg::U_MUL_D1 : mae_pkg::U_MUL_LOOP;
            end
          end
          default: disp = mae_pkg::U_OOS;
        endcase
      end
      default: disp = mae_pkg::U_IDLE;
    endcase
  end

  always_comb begin
    k_last = (k_q == ca - mae_pkg::DIM_W'(1));
    case (ctl.jump)
      mae_pkg::J_GOTO:     upc_d = ctl.target;
      mae_pkg::J_LOOP:     upc_d = k_last ? ctl.target : upc_q;
      mae_pkg::J_DISPATCH: upc_d = take ? disp : upc_q;
      mae_pkg::J_EMIT:     upc_d = out_free_i ? ctl.target : upc_q;
      default:             upc_d = mae_pkg::U_IDLE;
    endcase
  end

  always_comb begin
    k_d = k_q;
    if (ctl.clr) begin
      k_d = '0;
    end else if (ctl.rd_sel == mae_pkg::RD_MAC) begin
      k_d = k_q + mae_pkg::DIM_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= mae_pkg::U_IDLE;
      k_q   <= '0;
    end else begin
      upc_q <= upc_d;
      k_q   <= k_d;
    end
  end

endmodule

// ===== design/mae_dp.sv =====
// Datapath: element stores for A and B, multiplier, accumulator and result register.
// Driven by the control word of mae_seq; uses types from mae_pkg.
module mae_dp #(
  parameter int MAX_DIM = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mae_pkg::seq_out_t   seq_i,
  input  mae_pkg::in_item_t   in_item_i,
  output mae_pkg::out_item_t  res_o
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int ACC_W = 2 * mae_pkg::DATA_W + $clog2(MAX_DIM) + 1;

  logic [mae_pkg::DATA_W-1:0] mem_a [DEPTH];
  logic [mae_pkg::DATA_W-1:0] mem_b [DEPTH];

  logic [mae_pkg::DIM_W-1:0] r_q, c_q;
  logic signed [mae_pkg::DATA_W-1:0] v_q;
  logic signed [mae_pkg::DATA_W-1:0] a_rd_q, b_rd_q;
  logic signed [2*mae_pkg::DATA_W-1:0] prod_q;
  logic signed [ACC_W-1:0] acc_q, acc_d, rnd, shifted;
  logic rd_vld_q, prod_vld_q;
  logic [AW-1:0] wr_addr, a_addr, b_addr;
  logic signed [mae_pkg::DATA_W:0] sum, diff;
  mae_pkg::out_item_t res_q, res_d;

  function automatic logic [AW-1:0] elem_addr(logic [mae_pkg::DIM_W-1:0] row,
                                              logic [mae_pkg::DIM_W-1:0] col);
    return AW'(32'(row) * 32'(MAX_DIM) + 32'(col));
  endfunction

  function automatic logic signed [mae_pkg::DATA_W-1:0] sat(logic signed [mae_pkg::DATA_W:0] x);
    if (x[mae_pkg::DATA_W] != x[mae_pkg::DATA_W-1]) begin
      return x[mae_pkg::DATA_W] ? {1'b1, {(mae_pkg::DATA_W-1){1'b0}}}
                                : {1'b0, {(mae_pkg::DATA_W-1){1'b1}}};
    end
    return x[mae_pkg::DATA_W-1:0];
  endfunction

  always_comb begin
    wr_addr = elem_addr(r_q, c_q);
    case (seq_i.ctl.rd_sel)
      mae_pkg::RD_TRANS: begin
        a_addr = elem_addr(c_q, r_q);
        b_addr = wr_addr;
      end
      mae_pkg::RD_MAC: begin
        a_addr = elem_addr(r_q, seq_i.k);
        b_addr = elem_addr(seq_i.k, c_q);
      end
      default: begin
        a_addr = wr_addr;
        b_addr = wr_addr;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (seq_i.ctl.wr_a) mem_a[wr_addr] <= v_q;
    if (seq_i.ctl.wr_b) mem_b[wr_addr] <= v_q;
    a_rd_q <= mem_a[a_addr];
    b_rd_q <= mem_b[b_addr];
  end

  always_ff @(posedge clk_i) begin
    if (seq_i.take) begin
      r_q <= {1'b0, in_item_i.row};
      c_q <= {1'b0, in_item_i.col};
      v_q <= in_item_i.value;
    end
    prod_q <= a_rd_q * b_rd_q;
    acc_q  <= acc_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      rd_vld_q   <= (seq_i.ctl.rd_sel == mae_pkg::RD_MAC);
      prod_vld_q <= rd_vld_q;
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (seq_i.ctl.clr) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  always_comb begin
    sum     = {a_rd_q[mae_pkg::DATA_W-1], a_rd_q} + {b_rd_q[mae_pkg::DATA_W-1], b_rd_q};
    diff    = {a_rd_q[mae_pkg::DATA_W-1], a_rd_q} - {b_rd_q[mae_pkg::DATA_W-1], b_rd_q};
    rnd     = acc_q + ACC_W'(32'h8000);
    shifted = rnd >>> 16;
    res_d   = res_q;
    case (seq_i.ctl.res_sel)
      mae_pkg::RES_ELEM_A: res_d = '{result_value: a_rd_q, out_of_shape: 1'b0};
      mae_pkg::RES_ADD:    res_d = '{result_value: sat(sum), out_of_shape: 1'b0};
      mae_pkg::RES_SUB:    res_d = '{result_value: sat(diff), out_of_shape: 1'b0};
      mae_pkg::RES_ROUND: begin
        res_d.out_of_shape = 1'b0;
        if (shifted[ACC_W-1:mae_pkg::DATA_W-1] != {(ACC_W-mae_pkg::DATA_W+1){1'b0}} &&
            shifted[ACC_W-1:mae_pkg::DATA_W-1] != {(ACC_W-mae_pkg::DATA_W+1){1'b1}}) begin
          res_d.result_value = shifted[ACC_W-1] ? {1'b1, {(mae_pkg::DATA_W-1){1'b0}}}
                                                : {1'b0, {(mae_pkg::DATA_W-1){1'b1}}};
        end else begin
          res_d.result_value = shifted[mae_pkg::DATA_W-1:0];
        end
      end
      mae_pkg::RES_OOS:    res_d = '{result_value: '0, out_of_shape: 1'b1};
      default:             res_d = res_q;
    endcase
  end

  assign res_o = res_q;

endmodule

// ===== design/mae_checker.sv =====
// Port-level checker for matrix_arith_engine, attached by the bind statement below.
// Uses the item types from mae_pkg.
module mae_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input mae_pkg::in_item_t         in_data_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input mae_pkg::out_item_t        out_data_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_data_i.kind == mae_pkg::KIND_READ |=> in_stall_o)
    else $error("Read transfer did not occupy the engine.");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_data_i.kind == mae_pkg::KIND_LOAD_A ||
                in_data_i.kind == mae_pkg::KIND_LOAD_B) && !out_valid_o |=> !out_valid_o)
    else $error("Load transfer produced a result.");

  a_oos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_of_shape |-> out_data_o.result_value == '0)
    else $error("Out-of-shape result carries a nonzero value.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("Stalled result changed.");

endmodule

bind matrix_arith_engine mae_checker u_mae_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
